FILE: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, except while reset is high.
`define AMGS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define AMGS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/amgs_pkg.sv
`timescale 1ns / 1ps

package amgs_pkg;

  localparam int NODE_W     = 8;
  localparam int CNT_W      = 16;
  localparam int WEIGHT_IN_W = 16;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [2:0] OP_ADD_NODE    = 3'd0;
  localparam logic [2:0] OP_REMOVE_NODE = 3'd1;
  localparam logic [2:0] OP_ADD_EDGE    = 3'd2;
  localparam logic [2:0] OP_REMOVE_EDGE = 3'd3;
  localparam logic [2:0] OP_QUERY_NODE  = 3'd4;
  localparam logic [2:0] OP_QUERY_EDGE  = 3'd5;
  localparam logic [2:0] OP_NEIGHBOURS  = 3'd6;
  localparam logic [2:0] OP_CLEAR       = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd1;

  typedef struct packed {
    logic [2:0]                    opcode;
    logic [NODE_W-1:0]             node_a;
    logic [NODE_W-1:0]             node_b;
    logic signed [WEIGHT_IN_W-1:0] edge_weight;
  } amgs_cmd_t;

  typedef struct packed {
    logic              success;
    logic              neighbour_valid;
    logic [NODE_W-1:0] neighbour_id;
    logic              last;
    logic [CNT_W-1:0]  node_total;
    logic [CNT_W-1:0]  edge_total;
  } amgs_res_t;

endpackage

FILE: design/amgs_ram.sv
`timescale 1ns / 1ps

module amgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/adjacency_matrix_graph_store_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// cmd       cmd_valid / cmd_ready  cmd (amgs_cmd_t): opcode, node_a, node_b, edge_weight
// res       res_valid / res_ready  res (amgs_res_t): success, ..., edge_total
// cfg       cfg_we                 cfg_index, cfg_data
//
// One transaction is worked at a time over one matrix memory port.
// The first write into a row after a clear first zeroes that row.
// Reset clears the per-row valid flags at once; no clearing pass runs after reset.
// A full result register stalls the neighbour walk and the final result only.

module adjacency_matrix_graph_store_unit import amgs_pkg::*; #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  amgs_cmd_t             cmd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output amgs_res_t             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW       = $clog2(MAX_NODES);
  localparam int CW       = $clog2(MAX_NODES + 1);
  localparam int DEPTH    = MAX_NODES * (2 ** IW);
  localparam int IDW      = NODE_W + 1;
  localparam int CAP_RST  = (MAX_NODES < 16) ? MAX_NODES : 16;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDA      = 4'd1;
  localparam logic [3:0] S_CHKA     = 4'd2;
  localparam logic [3:0] S_CHKB     = 4'd3;
  localparam logic [3:0] S_CHKE     = 4'd4;
  localparam logic [3:0] S_WR       = 4'd5;
  localparam logic [3:0] S_COL      = 4'd6;
  localparam logic [3:0] S_SCAN_RD  = 4'd7;
  localparam logic [3:0] S_SCAN_CHK = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0]             state;
  amgs_cmd_t              cmd_q;
  logic                   base;
  logic [CW-1:0]          cap;
  logic [MAX_NODES-1:0]   row_valid;
  logic [CNT_W-1:0]       node_cnt;
  logic [CNT_W-1:0]       edge_cnt;
  logic [CW-1:0]          cnt;
  logic [IW-1:0]          wr_row;
  logic [IW-1:0]          wr_col;
  logic [WEIGHT_BITS-1:0] wr_val;
  logic                   rv_q;
  logic                   pend_valid;
  logic [NODE_W-1:0]      pend_id;
  logic                   em_ok;
  logic                   em_nv;
  logic [NODE_W-1:0]      em_id;

  logic [IDW-1:0]         diff_a;
  logic [IDW-1:0]         diff_b;
  logic                   va;
  logic                   vb;
  logic [IW-1:0]          ia;
  logic [IW-1:0]          ib;
  logic [IW-1:0]          ci;
  logic [CW-1:0]          cnt_inc;
  logic [NODE_W-1:0]      cnt_id;
  logic [IW-1:0]          rd_row;
  logic [IW-1:0]          rd_col;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [WEIGHT_BITS-1:0] eff;
  logic                   present;
  logic                   nonzero;
  logic                   hit;
  logic                   out_free;
  logic                   emit_mid;
  logic                   emit_fin;
  logic                   wr_single;
  logic                   wr_last;
  logic                   we;
  logic [IW-1:0]          w_row;
  logic [IW-1:0]          w_col;
  logic [WEIGHT_BITS-1:0] w_data;
  amgs_res_t              res_next;

  assign diff_a = {1'b0, cmd_q.node_a} - IDW'(base);
  assign diff_b = {1'b0, cmd_q.node_b} - IDW'(base);
  assign va = !diff_a[NODE_W] && (diff_a < IDW'(cap));
  assign vb = !diff_b[NODE_W] && (diff_b < IDW'(cap));
  assign ia = diff_a[IW-1:0];
  assign ib = diff_b[IW-1:0];
  assign ci = cnt[IW-1:0];
  assign cnt_inc = cnt + CW'(1);
  assign cnt_id = NODE_W'(cnt) + NODE_W'(base);

  always_comb begin
    rd_row = ia;
    rd_col = ia;
    case (state)
      S_CHKA: begin
        rd_row = ib;
        rd_col = ib;
      end
      S_CHKB: begin
        rd_col = ib;
      end
      S_SCAN_RD, S_SCAN_CHK: begin
        rd_col = ci;
      end
      default: begin
        rd_row = ia;
        rd_col = ia;
      end
    endcase
  end

  // A row whose valid flag is clear reads as all zero.
  assign eff = rv_q ? rd_data : '0;
  assign present = (eff == WEIGHT_BITS'(1));
  assign nonzero = (eff != '0);
  assign hit = nonzero && (ci != ia);

  assign out_free = !res_valid || res_ready;
  assign emit_mid = (state == S_SCAN_CHK) && hit && pend_valid && out_free;
  assign emit_fin = (state == S_EMIT) && out_free;

  assign wr_single = row_valid[wr_row];
  assign wr_last = (cnt == CW'(MAX_NODES - 1));

  always_comb begin
    we = 1'b0;
    w_row = wr_row;
    w_col = wr_col;
    w_data = wr_val;
    case (state)
      S_WR: begin
        we = 1'b1;
        if (!wr_single) begin
          w_col = ci;
          w_data = (ci == wr_col) ? wr_val : '0;
        end
      end
      S_COL: begin
        we = row_valid[ci];
        w_row = ci;
        w_col = ia;
        w_data = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  amgs_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(DEPTH)
  ) u_matrix (
    .clk  (clk),
    .we   (we),
    .waddr({w_row, w_col}),
    .wdata(w_data),
    .raddr({rd_row, rd_col}),
    .rdata(rd_data)
  );

  always_comb begin
    res_next.success = em_ok;
    res_next.neighbour_valid = em_nv;
    res_next.neighbour_id = em_id;
    res_next.last = 1'b1;
    res_next.node_total = node_cnt;
    res_next.edge_total = edge_cnt;
    if (emit_mid) begin
      res_next.success = 1'b1;
      res_next.neighbour_valid = 1'b1;
      res_next.neighbour_id = pend_id;
      res_next.last = 1'b0;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    rv_q <= row_valid[rd_row];
    if (emit_mid || emit_fin) begin
      res <= res_next;
    end
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base <= 1'b0;
      cap <= CW'(CAP_RST);
      row_valid <= '0;
      node_cnt <= '0;
      edge_cnt <= '0;
      res_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (emit_mid || emit_fin) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          em_ok <= 1'b0;
          em_nv <= 1'b0;
          em_id <= '0;
          cnt <= '0;
          if (cmd_q.opcode == OP_CLEAR) begin
            row_valid <= '0;
            em_ok <= 1'b1;
            state <= S_EMIT;
          end else if (!va) begin
            state <= S_EMIT;
          end else if (cmd_q.opcode == OP_ADD_NODE) begin
            wr_row <= ia;
            wr_col <= ia;
            wr_val <= WEIGHT_BITS'(1);
            state <= S_WR;
          end else begin
            state <= S_CHKA;
          end
        end
        S_CHKA: begin
          if (!present) begin
            state <= S_EMIT;
          end else begin
            case (cmd_q.opcode)
              OP_REMOVE_NODE: begin
                state <= S_COL;
              end
              OP_QUERY_NODE: begin
                em_ok <= 1'b1;
                state <= S_EMIT;
              end
              OP_NEIGHBOURS: begin
                pend_valid <= 1'b0;
                state <= S_SCAN_RD;
              end
              default: begin
                state <= vb ? S_CHKB : S_EMIT;
              end
            endcase
          end
        end
        S_CHKB: begin
          if (!present) begin
            state <= S_EMIT;
          end else if (cmd_q.opcode == OP_ADD_EDGE) begin
            wr_row <= ia;
            wr_col <= ib;
            wr_val <= WEIGHT_BITS'(cmd_q.edge_weight);
            state <= S_WR;
          end else begin
            state <= S_CHKE;
          end
        end
        S_CHKE: begin
          if (!nonzero) begin
            state <= S_EMIT;
          end else if (cmd_q.opcode == OP_REMOVE_EDGE) begin
            wr_row <= ia;
            wr_col <= ib;
            wr_val <= '0;
            state <= S_WR;
          end else begin
            em_ok <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_WR: begin
          if (wr_single || wr_last) begin
            row_valid[wr_row] <= 1'b1;
            case (cmd_q.opcode)
              OP_ADD_NODE: begin
                node_cnt <= node_cnt + CNT_W'(1);
              end
              OP_ADD_EDGE: begin
                edge_cnt <= edge_cnt + CNT_W'(1);
              end
              OP_REMOVE_EDGE: begin
                edge_cnt <= edge_cnt - CNT_W'(1);
              end
              default: begin
                edge_cnt <= edge_cnt;
              end
            endcase
            em_ok <= 1'b1;
            state <= S_EMIT;
          end else begin
            cnt <= cnt_inc;
          end
        end
        S_COL: begin
          if (cnt_inc == cap) begin
            row_valid[ia] <= 1'b0;
            node_cnt <= node_cnt - CNT_W'(1);
            em_ok <= 1'b1;
            state <= S_EMIT;
          end else begin
            cnt <= cnt_inc;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!(hit && pend_valid && !out_free)) begin
            if (hit) begin
              pend_valid <= 1'b1;
              pend_id <= cnt_id;
            end
            if (cnt_inc == cap) begin
              em_ok <= 1'b1;
              em_nv <= hit || pend_valid;
              em_id <= hit ? cnt_id : (pend_valid ? pend_id : '0);
              state <= S_EMIT;
            end else begin
              cnt <= cnt_inc;
              state <= S_SCAN_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_BASE: begin
            base <= cfg_data[0];
          end
          CFG_CAPACITY: begin
            if (int'(cfg_data) > MAX_NODES) begin
              cap <= CW'(MAX_NODES);
            end else begin
              cap <= CW'(cfg_data);
            end
            row_valid <= '0;
          end
          default: begin
            base <= base;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/amgs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amgs_checker import amgs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input amgs_res_t res,
  input logic      res_valid,
  input logic      res_ready
);

  // A waiting result keeps its contents until it is taken.
  `AMGS_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res), "result changed while stalled")

  // Only one command is worked at a time.
  `AMGS_ASSERT(a_busy_after_accept, clk, rst, cmd_valid && cmd_ready |=> !cmd_ready, "ready right after an accepted command")

  // A neighbour entry only comes from a successful listing, and an empty id otherwise.
  `AMGS_ASSERT(a_nbr_success, clk, rst, res_valid && res.neighbour_valid |-> res.success, "neighbour without success")
  `AMGS_ASSERT(a_nbr_id_zero, clk, rst, res_valid && !res.neighbour_valid |-> res.neighbour_id == 0, "id set without a neighbour")

  // Reset empties the result register.
  `AMGS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind adjacency_matrix_graph_store_unit amgs_checker u_amgs_checker (.*);
